/* hdl/buddy_tree_allocator_top_defines.svh */
// ---------------------------------------------------------------------------
// Buddy tree allocator assertion macros
// Shared concurrent check forms, clocked on i_clk, quiet in reset.
// ---------------------------------------------------------------------------
`ifndef BUDDY_TREE_ALLOCATOR_TOP_DEFINES_SVH
`define BUDDY_TREE_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication.
`define BTA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BTA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/bta_pkg.sv */
// ---------------------------------------------------------------------------
// Buddy tree allocator package
// Widths, codes and request/response types.
// ---------------------------------------------------------------------------
`default_nettype none

package bta_pkg;

    localparam int ORDER_LIMIT = 10;
    localparam int NODE_COUNT  = 1 << ORDER_LIMIT;
    localparam int ADDR_W      = $clog2(NODE_COUNT);
    localparam int IDX_W       = ADDR_W + 1;
    localparam int ORD_W       = 4;
    localparam int OFF_W       = 10;
    localparam int CNT_W       = 11;
    localparam int CNT_DEPTH   = ORDER_LIMIT + 1;
    localparam int CNT_AW      = $clog2(CNT_DEPTH);

    localparam logic [ORD_W-1:0] TOP_RESET = ORD_W'(ORDER_LIMIT);

    localparam logic [CNT_W-1:0] CNT_INC1 = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_INC2 = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_DEC1 = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_DEC2 = {{(CNT_W-1){1'b1}}, 1'b0};

    localparam logic [1:0] OP_FIND   = 2'd0;
    localparam logic [1:0] OP_SPLIT  = 2'd1;
    localparam logic [1:0] OP_OCCUPY = 2'd2;
    localparam logic [1:0] OP_RETURN = 2'd3;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_NONE  = 3'd1;
    localparam logic [2:0] ST_RANGE = 3'd2;
    localparam logic [2:0] ST_STATE = 3'd3;
    localparam logic [2:0] ST_COUNT = 3'd4;
    localparam logic [2:0] ST_TREE  = 3'd5;

    typedef enum logic [1:0] {
        ND_ABSENT = 2'd0,
        ND_FREE   = 2'd1,
        ND_OCC    = 2'd2,
        ND_SPLIT  = 2'd3
    } t_node;

    typedef struct packed {
        logic [1:0]       operation;
        logic [ORD_W-1:0] block_order;
        logic [OFF_W-1:0] block_offset;
        logic [ORD_W-1:0] split_target;
    } t_req;

    typedef struct packed {
        logic [2:0]       status;
        logic [ORD_W-1:0] result_order;
        logic [OFF_W-1:0] result_offset;
    } t_rsp;

endpackage

`default_nettype wire

/* hdl/buddy_tree_allocator_top.sv */
// ---------------------------------------------------------------------------
// Buddy tree allocator
// Heap-ordered buddy tree in node and leaf RAMs with per-order free counts.
// ---------------------------------------------------------------------------
//  channel   | ports                      | handshake
//  ----------+----------------------------+-------------------------------
//  request   | i_req                      | start high while busy low
//  response  | o_rsp                      | o_done pulse, one cycle, no stall
//  config    | i_cfg_data                 | i_cfg_we, taken on any edge
//
//  One request at a time; each tree access is a registered RAM read
//  then a compare. Decode and state check come first, then split halves
//  the block level by level, occupy climbs the tree, return merges buddies
//  and undoes occupied marks; find scans the orders, visits nodes and steps
//  back up the tree.
//  Reset and every top_order write run a clearing pass over every RAM
//  address with busy high. The receiver cannot stall responses.
// ---------------------------------------------------------------------------
`default_nettype none
`include "buddy_tree_allocator_top_defines.svh"

module buddy_tree_allocator_top
    import bta_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire t_req             i_req,
    output t_rsp                  o_rsp,
    output logic                  o_done,
    input  wire logic             i_cfg_we,
    input  wire logic [ORD_W-1:0] i_cfg_data
);

    typedef enum logic [29:0] {
        S_CLEAR = 30'd1 << 0,  S_IDLE = 30'd1 << 1,  S_DEC  = 30'd1 << 2,
        S_FSCAN = 30'd1 << 3,  S_FVIS = 30'd1 << 4,  S_FCHK = 30'd1 << 5,
        S_FUP   = 30'd1 << 6,  S_CHK0 = 30'd1 << 7,  S_SRDL = 30'd1 << 8,
        S_SRDR  = 30'd1 << 9,  S_SCKR = 30'd1 << 10, S_SW1  = 30'd1 << 11,
        S_SW2   = 30'd1 << 12, S_SW3  = 30'd1 << 13, S_OW   = 30'd1 << 14,
        S_OP    = 30'd1 << 15, S_OB   = 30'd1 << 16, S_OC   = 30'd1 << 17,
        S_OW2   = 30'd1 << 18, S_RW   = 30'd1 << 19, S_RP   = 30'd1 << 20,
        S_RB    = 30'd1 << 21, S_RC   = 30'd1 << 22, S_RM1  = 30'd1 << 23,
        S_RM2   = 30'd1 << 24, S_RM3  = 30'd1 << 25, S_UP   = 30'd1 << 26,
        S_UL    = 30'd1 << 27, S_UC   = 30'd1 << 28, S_UW   = 30'd1 << 29
    } t_state;

    // Control and working registers
    t_state             r_state, n_state;
    logic [ORD_W-1:0]   r_top;
    logic [1:0]         r_op, n_op;
    logic [ORD_W-1:0]   r_ord, n_ord;
    logic [ORD_W-1:0]   r_tgt, n_tgt;
    logic [ORD_W-1:0]   r_scan, n_scan;
    logic [OFF_W-1:0]   r_off, n_off;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [IDX_W-1:0]   r_ci, n_ci;
    logic [ORD_W-1:0]   r_co, n_co;
    logic               r_fail, n_fail;
    logic [ADDR_W-1:0]  r_clr_cnt;
    logic               r_done, n_done;
    t_rsp               r_rsp, n_rsp;
    logic [CNT_W-1:0]   r_cnt [CNT_DEPTH];

    // Tree storage
    t_node              r_node_mem [NODE_COUNT];
    logic               r_leaf_mem [NODE_COUNT];
    t_node              r_node_q;
    logic               r_leaf_q;
    logic [ORD_W-1:0]   r_rd_ord;

    // RAM access for the current cycle
    logic [IDX_W-1:0]   mem_idx;
    logic [ORD_W-1:0]   mem_ord;
    logic               node_we, leaf_we, leaf_wd;
    t_node              node_wd;
    logic [IDX_W-1:0]   leaf_sub;
    logic [ADDR_W-1:0]  node_addr, leaf_addr;

    // Free count port
    logic [CNT_AW-1:0]  cnt_sel;
    logic               cnt_we;
    logic [CNT_W-1:0]   cnt_delta, cnt_rd;

    t_node              cur;
    logic [IDX_W-1:0]   lvl_size, base_idx, lvl_co, lchild_idx, par_idx;
    logic               in_range, child_fail;
    logic [ORD_W-1:0]   ord_dn, ord_up;

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // Read data of the previous cycle, leaves decode to free or occupied
    assign cur = (r_rd_ord == '0) ? (r_leaf_q ? ND_FREE : ND_OCC) : r_node_q;

    assign lvl_size   = IDX_W'(1) << (r_top - r_ord);
    assign base_idx   = lvl_size + IDX_W'(r_off);
    assign in_range   = (r_ord <= r_top) && (IDX_W'(r_off) < lvl_size);
    assign lvl_co     = IDX_W'(1) << (r_top - r_co);
    assign lchild_idx = {r_idx[IDX_W-2:0], 1'b0};
    assign par_idx    = {1'b0, r_idx[IDX_W-1:1]};
    assign ord_dn     = r_ord - ORD_W'(1);
    assign ord_up     = r_ord + ORD_W'(1);

    // Child of a split must be absent; a leaf child must not be free
    assign child_fail = (r_rd_ord != '0) ? (cur != ND_ABSENT) : (cur == ND_FREE);

    assign leaf_sub  = mem_idx - (IDX_W'(1) << r_top);
    assign node_addr = (r_state == S_CLEAR) ? r_clr_cnt : mem_idx[ADDR_W-1:0];
    assign leaf_addr = (r_state == S_CLEAR) ? r_clr_cnt : leaf_sub[ADDR_W-1:0];
    assign cnt_rd    = r_cnt[cnt_sel];

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_ord     = r_ord;
        n_tgt     = r_tgt;
        n_scan    = r_scan;
        n_off     = r_off;
        n_idx     = r_idx;
        n_ci      = r_ci;
        n_co      = r_co;
        n_fail    = r_fail;
        n_done    = 1'b0;
        n_rsp     = r_rsp;
        mem_idx   = r_idx;
        mem_ord   = r_ord;
        node_we   = 1'b0;
        node_wd   = ND_ABSENT;
        leaf_we   = 1'b0;
        leaf_wd   = 1'b0;
        cnt_sel   = CNT_AW'(r_ord);
        cnt_we    = 1'b0;
        cnt_delta = CNT_INC1;

        unique case (r_state)
            S_CLEAR: begin
                // Sweep both RAMs; root comes back free
                node_we = 1'b1;
                node_wd = (r_clr_cnt == ADDR_W'(1) && r_top != '0) ? ND_FREE : ND_ABSENT;
                leaf_we = 1'b1;
                leaf_wd = (r_clr_cnt == '0 && r_top == '0);
                if (r_clr_cnt == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_op    = i_req.operation;
                    n_ord   = i_req.block_order;
                    n_off   = i_req.block_offset;
                    n_tgt   = i_req.split_target;
                    n_scan  = i_req.block_order;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_idx   = base_idx;
                mem_idx = base_idx;
                n_fail  = 1'b0;
                n_rsp   = '0;
                case (r_op)
                    OP_FIND: begin
                        n_state = S_FSCAN;
                    end
                    OP_SPLIT: begin
                        if (r_ord > r_top || r_tgt > r_ord) begin
                            n_rsp.status = ST_RANGE;
                            n_done = 1'b1;
                            n_state = S_IDLE;
                        end else if (r_ord == r_tgt || !in_range) begin
                            n_rsp.status = in_range ? ST_OK : ST_RANGE;
                            n_done = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_CHK0;
                        end
                    end
                    default: begin
                        if (!in_range) begin
                            n_rsp.status = ST_RANGE;
                            n_done = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_CHK0;
                        end
                    end
                endcase
            end
            S_FSCAN: begin
                // Advance to the first order with a nonzero free count
                cnt_sel = CNT_AW'(r_scan);
                if (r_scan > r_top) begin
                    n_rsp.status = ST_NONE;
                    n_done = 1'b1;
                    n_state = S_IDLE;
                end else if (cnt_rd != '0) begin
                    n_idx   = IDX_W'(1);
                    n_ord   = r_top;
                    n_state = S_FVIS;
                end else begin
                    n_scan = r_scan + ORD_W'(1);
                end
            end
            S_FVIS: begin
                n_state = (r_ord < r_scan) ? S_FUP : S_FCHK;
            end
            S_FCHK: begin
                if (cur == ND_FREE) begin
                    n_rsp.status        = ST_OK;
                    n_rsp.result_order  = r_ord;
                    n_rsp.result_offset = OFF_W'(r_idx - lvl_size);
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (cur == ND_SPLIT && r_ord != '0) begin
                    n_idx   = lchild_idx;
                    n_ord   = ord_dn;
                    n_state = S_FVIS;
                end else begin
                    n_state = S_FUP;
                end
            end
            S_FUP: begin
                // Climb past right children, then step to the right sibling
                if (r_idx == IDX_W'(1)) begin
                    n_rsp.status = ST_COUNT;
                    n_done = 1'b1;
                    n_state = S_IDLE;
                end else if (r_idx[0]) begin
                    n_idx = par_idx;
                    n_ord = ord_up;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_FVIS;
                end
            end
            S_CHK0: begin
                if ((r_op == OP_RETURN) ? (cur != ND_OCC) : (cur != ND_FREE)) begin
                    n_rsp.status = ST_STATE;
                    n_done = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    case (r_op)
                        OP_SPLIT:  n_state = S_SRDL;
                        OP_OCCUPY: n_state = S_OW;
                        default:   n_state = S_RW;
                    endcase
                end
            end
            S_SRDL: begin
                mem_idx = lchild_idx;
                mem_ord = ord_dn;
                n_state = S_SRDR;
            end
            S_SRDR: begin
                n_fail  = child_fail;
                mem_idx = lchild_idx | IDX_W'(1);
                mem_ord = ord_dn;
                n_state = S_SCKR;
            end
            S_SCKR: begin
                if (r_fail || child_fail) begin
                    n_rsp.status = ST_TREE;
                    n_done = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SW1;
                end
            end
            S_SW1: begin
                node_we   = 1'b1;
                node_wd   = ND_SPLIT;
                cnt_we    = 1'b1;
                cnt_delta = CNT_DEC1;
                n_state   = S_SW2;
            end
            S_SW2, S_SW3: begin
                mem_idx = (r_state == S_SW2) ? lchild_idx : (lchild_idx | IDX_W'(1));
                mem_ord = ord_dn;
                node_we = (ord_dn != '0);
                node_wd = ND_FREE;
                leaf_we = (ord_dn == '0);
                leaf_wd = 1'b1;
                if (r_state == S_SW2) begin
                    cnt_sel   = CNT_AW'(ord_dn);
                    cnt_we    = 1'b1;
                    cnt_delta = CNT_INC2;
                    n_state   = S_SW3;
                end else begin
                    n_idx = lchild_idx;
                    n_ord = ord_dn;
                    if (ord_dn == r_tgt) begin
                        n_rsp.status = ST_OK;
                        n_done = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_SRDL;
                    end
                end
            end
            S_OW: begin
                node_we   = (r_ord != '0);
                node_wd   = ND_OCC;
                leaf_we   = (r_ord == '0);
                leaf_wd   = 1'b0;
                cnt_we    = 1'b1;
                cnt_delta = CNT_DEC1;
                n_state   = S_OP;
            end
            S_OP, S_RP, S_UP: begin
                mem_idx = par_idx;
                mem_ord = ord_up;
                if (r_ord == r_top) begin
                    if (r_state == S_OP) begin
                        n_rsp.status = ST_OK;
                        n_done = 1'b1;
                        n_state = S_IDLE;
                    end else if (r_state == S_RP) begin
                        n_ci = r_idx;
                        n_co = r_ord;
                        n_state = S_UP;
                    end else begin
                        n_rsp.status        = ST_OK;
                        n_rsp.result_order  = r_co;
                        n_rsp.result_offset = OFF_W'(r_ci - lvl_co);
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    case (r_state)
                        S_OP:    n_state = S_OB;
                        S_RP:    n_state = S_RB;
                        default: n_state = S_UL;
                    endcase
                end
            end
            S_OB: begin
                n_fail  = (cur != ND_SPLIT);
                mem_idx = r_idx ^ IDX_W'(1);
                n_state = S_OC;
            end
            S_OC: begin
                if (r_fail || cur != ND_OCC) begin
                    n_rsp.status = ST_OK;
                    n_done = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_OW2;
                end
            end
            S_OW2, S_UW, S_RM3: begin
                mem_idx = par_idx;
                node_we = 1'b1;
                case (r_state)
                    S_OW2: begin
                        node_wd = ND_OCC;
                        n_state = S_OP;
                    end
                    S_UW: begin
                        node_wd = ND_SPLIT;
                        n_state = S_UP;
                    end
                    default: begin
                        node_wd   = ND_FREE;
                        cnt_sel   = CNT_AW'(ord_up);
                        cnt_we    = 1'b1;
                        cnt_delta = CNT_INC1;
                        n_state   = S_RP;
                    end
                endcase
                n_idx = par_idx;
                n_ord = ord_up;
            end
            S_RW: begin
                node_we   = (r_ord != '0);
                node_wd   = ND_FREE;
                leaf_we   = (r_ord == '0);
                leaf_wd   = 1'b1;
                cnt_we    = 1'b1;
                cnt_delta = CNT_INC1;
                n_state   = S_RP;
            end
            S_RB: begin
                mem_idx = r_idx ^ IDX_W'(1);
                if (cur != ND_SPLIT && cur != ND_OCC) begin
                    n_rsp.status = ST_TREE;
                    n_done = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_RC;
                end
            end
            S_RC: begin
                if (cur != ND_FREE) begin
                    n_ci = r_idx;
                    n_co = r_ord;
                    n_state = S_UP;
                end else begin
                    n_state = S_RM1;
                end
            end
            S_RM1, S_RM2: begin
                // Drop both halves of the merged pair
                mem_idx = (r_state == S_RM1) ? r_idx : (r_idx ^ IDX_W'(1));
                node_we = (r_ord != '0);
                node_wd = ND_ABSENT;
                leaf_we = (r_ord == '0);
                leaf_wd = 1'b0;
                if (r_state == S_RM1) begin
                    cnt_we    = 1'b1;
                    cnt_delta = CNT_DEC2;
                    n_state   = S_RM2;
                end else begin
                    n_state = S_RM3;
                end
            end
            S_UL: begin
                mem_idx = {r_idx[IDX_W-1:1], 1'b0};
                if (cur != ND_OCC) begin
                    n_rsp.status        = (cur == ND_ABSENT) ? ST_TREE : ST_OK;
                    n_rsp.result_order  = (cur == ND_ABSENT) ? '0 : r_co;
                    n_rsp.result_offset = (cur == ND_ABSENT) ? '0 : OFF_W'(r_ci - lvl_co);
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_UC;
                end
            end
            S_UC: begin
                if (cur == ND_ABSENT) begin
                    n_rsp.status        = ST_OK;
                    n_rsp.result_order  = r_co;
                    n_rsp.result_offset = OFF_W'(r_ci - lvl_co);
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_UW;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state; a top_order write restarts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_top     <= TOP_RESET;
            r_clr_cnt <= '0;
            r_done    <= 1'b0;
        end else if (i_cfg_we) begin
            r_state   <= S_CLEAR;
            r_top     <= (i_cfg_data > ORD_W'(ORDER_LIMIT)) ? ORD_W'(ORDER_LIMIT) : i_cfg_data;
            r_clr_cnt <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= (r_state == S_CLEAR) ? r_clr_cnt + ADDR_W'(1) : '0;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_ord  <= n_ord;
        r_tgt  <= n_tgt;
        r_scan <= n_scan;
        r_off  <= n_off;
        r_idx  <= n_idx;
        r_ci   <= n_ci;
        r_co   <= n_co;
        r_fail <= n_fail;
        r_rsp  <= n_rsp;
    end

    // Free counts: one read-modify-write per cycle, wrap in CNT_W bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            for (int i = 0; i < CNT_DEPTH; i++) begin
                if (!i_rst_n) begin
                    r_cnt[i] <= (i == int'(TOP_RESET)) ? CNT_INC1 : '0;
                end else begin
                    r_cnt[i] <= (ORD_W'(i) == ((i_cfg_data > ORD_W'(ORDER_LIMIT)) ?
                                 ORD_W'(ORDER_LIMIT) : i_cfg_data)) ? CNT_INC1 : '0;
                end
            end
        end else if (cnt_we && cnt_sel < CNT_AW'(CNT_DEPTH)) begin
            r_cnt[cnt_sel] <= cnt_rd + cnt_delta;
        end
    end

    // Node and leaf RAMs, read data registered
    always_ff @(posedge i_clk) begin
        if (node_we) begin
            r_node_mem[node_addr] <= node_wd;
        end
        if (leaf_we) begin
            r_leaf_mem[leaf_addr] <= leaf_wd;
        end
        r_node_q <= r_node_mem[node_addr];
        r_leaf_q <= r_leaf_mem[leaf_addr];
        r_rd_ord <= mem_ord;
    end

    `BTA_ASSERT_IMP(a_done_from_work, o_done, $past(r_state != S_IDLE && r_state != S_CLEAR), "response without a request in flight")
    `BTA_ASSERT_NXT(a_done_pulse, o_done, !o_done, "response strobe longer than one cycle")
    `BTA_ASSERT_NXT(a_start_busy, start && !busy && !i_cfg_we, busy, "request taken but busy stayed low")
    `BTA_ASSERT_IMP(a_status_code, o_done, o_rsp.status <= ST_TREE, "undefined status code")

endmodule

`default_nettype wire
